// ===== hdl/pbs_pkg.sv =====
package pbs_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_TAKE   = 2'd2;
    localparam logic [1:0] CMD_PURGE  = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_NONE  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] seq_in;
        logic [7:0]  kind_in;
        logic [15:0] tag_in;
        logic [5:0]  stop_pos;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] seq_high;
        logic [15:0] tag_out;
        logic [5:0]  used_count;
    } out_t;

    // stored entry, sequence number kept apart since its width varies
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  kind;
        logic [15:0] tag;
        logic        mark;
    } entry_t;

    // token walking down the row of cells
    typedef struct packed {
        logic        active;
        logic        hit;
        logic [15:0] max;
        logic [15:0] tag;
    } probe_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== hdl/pbs_cell.sv =====
module pbs_cell #(
    parameter int IDX      = 0,
    parameter int SEQ_BITS = 16,
    parameter int CW       = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pbs_pkg::in_t       key,
    input  pbs_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]      fill,
    input  pbs_pkg::probe_t    probe_in,
    output pbs_pkg::probe_t    probe_out,
    input  pbs_pkg::entry_t    nb_ent,
    input  logic [SEQ_BITS-1:0] nb_seq,
    output pbs_pkg::entry_t    ent,
    output logic [SEQ_BITS-1:0] seq
);

    pbs_pkg::entry_t     ent_reg;
    logic [SEQ_BITS-1:0] seq_reg;
    pbs_pkg::probe_t     probe_reg, probe_next;
    logic                take_hit;
    logic                valid;
    logic                sd_match;

    assign valid    = CW'(IDX) < fill;
    assign sd_match = (ent_reg.src == key.src_addr) && (ent_reg.dst == key.dst_addr);

    always_comb
    begin
        probe_next = probe_in;
        take_hit   = 1'b0;
        if (probe_in.active && valid)
        begin
            case (key.cmd)
                pbs_pkg::CMD_INSERT:
                begin
                    if (sd_match && seq_reg == SEQ_BITS'(key.seq_in) &&
                        ent_reg.kind == key.kind_in)
                        probe_next.hit = 1'b1;
                end
                pbs_pkg::CMD_QUERY:
                begin
                    if (sd_match && 16'(seq_reg) > probe_in.max)
                        probe_next.max = 16'(seq_reg);
                end
                pbs_pkg::CMD_TAKE:
                begin
                    if (!probe_in.hit && ent_reg.src == key.src_addr && !ent_reg.mark)
                    begin
                        take_hit       = 1'b1;
                        probe_next.hit = 1'b1;
                        probe_next.tag = ent_reg.tag;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= '0;
        else
            probe_reg <= probe_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ent_reg.src  <= key.src_addr;
            ent_reg.dst  <= key.dst_addr;
            ent_reg.kind <= key.kind_in;
            ent_reg.tag  <= key.tag_in;
            ent_reg.mark <= 1'b0;
            seq_reg      <= SEQ_BITS'(key.seq_in);
        end
        else if (ctl.shift)
        begin
            ent_reg <= nb_ent;
            seq_reg <= nb_seq;
        end
        else if (take_hit)
            ent_reg.mark <= 1'b1;
    end

    assign probe_out = probe_reg;
    assign ent       = ent_reg;
    assign seq       = seq_reg;

endmodule

// ===== hdl/packet_bundle_store_core.sv =====
// Store of up to DEPTH packet descriptors held in a row of cells, one entry
// per cell, in arrival order. Insert, query and take-oldest send a token down
// the row, one cell per clock; purge walks the held entries one per clock,
// shifting the tail left over each removed entry. One command is worked at a
// time; a new command is taken while the previous result still waits in the
// output register. Entries need no clearing after reset: only cells below the
// fill count take part.
module packet_bundle_store_core #(
    parameter int DEPTH    = 32,
    parameter int SEQ_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pbs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pbs_pkg::out_t out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PURGE = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]    state_reg, state_next;
    pbs_pkg::in_t  key_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] p_reg, p_next;
    pbs_pkg::out_t res_reg, res_next;
    pbs_pkg::out_t out_reg;
    logic          out_valid_reg, out_valid_next;
    logic          start;
    logic          do_load;
    logic          do_shift;
    logic          accept;

    pbs_pkg::probe_t     probe_w [0:DEPTH];
    pbs_pkg::entry_t     ent_w   [0:DEPTH-1];
    logic [SEQ_BITS-1:0] seq_w   [0:DEPTH-1];
    logic [DEPTH-1:0]    mark_vec;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    assign probe_w[0] = '{active: start, hit: 1'b0, max: 16'd0, tag: 16'd0};

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            pbs_pkg::cell_ctl_t ctl;
            assign ctl.load  = do_load && (fill_reg == CW'(k));
            assign ctl.shift = do_shift && (CW'(k) >= p_reg);
            assign mark_vec[k] = ent_w[k].mark;
            if (k == DEPTH - 1)
            begin : g_last
                pbs_cell #(.IDX(k), .SEQ_BITS(SEQ_BITS), .CW(CW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .key(key_reg), .ctl(ctl), .fill(fill_reg),
                    .probe_in(probe_w[k]), .probe_out(probe_w[k+1]),
                    .nb_ent(ent_w[k]), .nb_seq(seq_w[k]),
                    .ent(ent_w[k]), .seq(seq_w[k])
                );
            end
            else
            begin : g_mid
                pbs_cell #(.IDX(k), .SEQ_BITS(SEQ_BITS), .CW(CW)) u_cell (
                    .clk(clk), .rst_n(rst_n), .key(key_reg), .ctl(ctl), .fill(fill_reg),
                    .probe_in(probe_w[k]), .probe_out(probe_w[k+1]),
                    .nb_ent(ent_w[k+1]), .nb_seq(seq_w[k+1]),
                    .ent(ent_w[k]), .seq(seq_w[k])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        start          = 1'b0;
        do_load        = 1'b0;
        do_shift       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    n_next = fill_reg;
                    j_next = '0;
                    p_next = '0;
                    if (in_data.cmd == pbs_pkg::CMD_PURGE)
                        state_next = S_PURGE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // token enters cell 0 on the first scan cycle only
                start = (j_reg == '0);
                j_next = CW'(1);
                if (probe_w[DEPTH].active)
                begin
                    res_next = '0;
                    case (key_reg.cmd)
                        pbs_pkg::CMD_INSERT:
                        begin
                            if (probe_w[DEPTH].hit)
                                res_next.status = pbs_pkg::ST_DUP;
                            else if (fill_reg == CW'(DEPTH))
                                res_next.status = pbs_pkg::ST_FULL;
                            else
                            begin
                                do_load   = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        pbs_pkg::CMD_QUERY:
                            res_next.seq_high = probe_w[DEPTH].max;
                        default:
                        begin
                            if (probe_w[DEPTH].hit)
                                res_next.tag_out = probe_w[DEPTH].tag;
                            else
                                res_next.status = pbs_pkg::ST_NONE;
                        end
                    endcase
                    res_next.used_count = 6'(fill_next);
                    state_next = S_FIN;
                end
            end
            S_PURGE:
            begin
                if (n_reg == '0)
                begin
                    res_next   = '{status: pbs_pkg::ST_EMPTY, seq_high: 16'd0,
                                   tag_out: 16'd0, used_count: 6'd0};
                    state_next = S_FIN;
                end
                else if (j_reg == n_reg)
                begin
                    res_next   = '{status: pbs_pkg::ST_OK, seq_high: 16'd0,
                                   tag_out: 16'd0, used_count: 6'(fill_reg)};
                    state_next = S_FIN;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                    if (j_reg < key_reg.stop_pos && mark_vec[p_reg[IW-1:0]])
                    begin
                        do_shift  = 1'b1;
                        fill_next = fill_reg - CW'(1);
                    end
                    else
                        p_next = p_reg + CW'(1);
                end
            end
            default:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            key_reg <= in_data;
        res_reg <= res_next;
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/pbs_checker.sv =====
module pbs_checker #(
    parameter int DEPTH = 32
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input pbs_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input pbs_pkg::out_t out_data
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("command changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= pbs_pkg::ST_EMPTY &&
                      32'(out_data.used_count) <= DEPTH)
        else $error("status or count out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != pbs_pkg::ST_OK |->
            out_data.seq_high == 16'd0 && out_data.tag_out == 16'd0)
        else $error("failed command returned data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == pbs_pkg::ST_FULL |->
            32'(out_data.used_count) == DEPTH)
        else $error("full reported below depth");

endmodule

bind packet_bundle_store_core pbs_checker #(.DEPTH(DEPTH)) u_pbs_checker (.*);

// ===== test/store_checker.sv =====
`timescale 1ns / 100ps

module store_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  pbs_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  pbs_pkg::out_t out_data,
    output int            fail_count,
    output int            pending,
    output int            result_count
);
    localparam int SLOTS = 32;

    logic [31:0]   slot_src  [SLOTS];
    logic [31:0]   slot_dst  [SLOTS];
    logic [15:0]   slot_seq  [SLOTS];
    logic [7:0]    slot_kind [SLOTS];
    logic [15:0]   slot_tag  [SLOTS];
    logic          slot_mark [SLOTS];
    int            held;
    pbs_pkg::out_t expected_results[$];

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // applies one command to the shadow store and returns its result
    function automatic pbs_pkg::out_t apply_command(input pbs_pkg::in_t c);
        pbs_pkg::out_t r;
        int            w;
        r = '0;
        case (c.cmd)
            pbs_pkg::CMD_INSERT:
            begin
                r.status = pbs_pkg::ST_OK;
                for (int i = 0; i < held; i++)
                    if (slot_src[i] == c.src_addr && slot_dst[i] == c.dst_addr
                        && slot_seq[i] == c.seq_in && slot_kind[i] == c.kind_in)
                        r.status = pbs_pkg::ST_DUP;
                if (r.status == pbs_pkg::ST_OK && held >= SLOTS)
                    r.status = pbs_pkg::ST_FULL;
                if (r.status == pbs_pkg::ST_OK)
                begin
                    slot_src[held]  = c.src_addr;
                    slot_dst[held]  = c.dst_addr;
                    slot_seq[held]  = c.seq_in;
                    slot_kind[held] = c.kind_in;
                    slot_tag[held]  = c.tag_in;
                    slot_mark[held] = 1'b0;
                    held++;
                end
            end
            pbs_pkg::CMD_QUERY:
                for (int i = 0; i < held; i++)
                    if (slot_src[i] == c.src_addr && slot_dst[i] == c.dst_addr
                        && slot_seq[i] > r.seq_high)
                        r.seq_high = slot_seq[i];
            pbs_pkg::CMD_TAKE:
            begin
                r.status = pbs_pkg::ST_NONE;
                for (int i = 0; i < held; i++)
                    if (r.status == pbs_pkg::ST_NONE && slot_src[i] == c.src_addr
                        && !slot_mark[i])
                    begin
                        slot_mark[i] = 1'b1;
                        r.tag_out    = slot_tag[i];
                        r.status     = pbs_pkg::ST_OK;
                    end
            end
            default:
                if (held == 0)
                    r.status = pbs_pkg::ST_EMPTY;
                else
                begin
                    w = 0;
                    for (int i = 0; i < held; i++)
                        if (!(i < c.stop_pos && slot_mark[i]))
                        begin
                            slot_src[w]  = slot_src[i];
                            slot_dst[w]  = slot_dst[i];
                            slot_seq[w]  = slot_seq[i];
                            slot_kind[w] = slot_kind[i];
                            slot_tag[w]  = slot_tag[i];
                            slot_mark[w] = slot_mark[i];
                            w++;
                        end
                    held = w;
                end
        endcase
        r.used_count = 6'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pbs_pkg::out_t want;
        if (!rst_n)
        begin
            held = 0;
            fail_count = 0;
            result_count = 0;
            pending = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    report("unexpected result transfer", 16'd0, 16'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status != want.status)
                        report("status", 16'(out_data.status), 16'(want.status));
                    if (out_data.seq_high != want.seq_high)
                        report("seq_high", out_data.seq_high, want.seq_high);
                    if (out_data.tag_out != want.tag_out)
                        report("tag_out", out_data.tag_out, want.tag_out);
                    if (out_data.used_count != want.used_count)
                        report("used_count", 16'(out_data.used_count),
                               16'(want.used_count));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(in_data));
            pending = expected_results.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_CMDS = 1700;
    localparam int CYCLE_LIMIT = 400000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    pbs_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    pbs_pkg::out_t out_data;
    int            fail_count, pending, result_count;
    int            cycles = 0;

    logic [31:0] src_pool [4];
    logic [31:0] dst_pool [3];

    always #6 clk = ~clk;

    packet_bundle_store_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    store_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls, with calm stretches
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // valid stays high after the transfer unless an idle gap follows
    task automatic send(input pbs_pkg::in_t c, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic pbs_pkg::in_t make_cmd(input logic [1:0] op, input logic [31:0] s,
                                              input logic [31:0] d, input logic [15:0] q,
                                              input logic [7:0] k, input logic [5:0] stop);
        pbs_pkg::in_t c;
        c = '0;
        c.cmd = op; c.src_addr = s; c.dst_addr = d; c.seq_in = q;
        c.kind_in = k; c.tag_in = 16'($urandom); c.stop_pos = stop;
        return c;
    endfunction

    function automatic pbs_pkg::in_t random_cmd(input bit noise);
        pbs_pkg::in_t c;
        c = make_cmd(2'($urandom_range(0, 3)), src_pool[$urandom_range(0, 3)],
                     dst_pool[$urandom_range(0, 2)], 16'($urandom_range(0, 7)),
                     8'($urandom_range(0, 1)), 6'($urandom_range(0, 40)));
        // favor inserts so the store fills and drains
        if ($urandom_range(0, 9) < 4)
            c.cmd = pbs_pkg::CMD_INSERT;
        if ($urandom_range(0, 5) == 0)
            c.seq_in = 16'($urandom);
        if (noise)
        begin
            c.src_addr = $urandom; c.dst_addr = $urandom; c.kind_in = 8'($urandom);
            c.stop_pos = 6'($urandom);
        end
        return c;
    endfunction

    initial
    begin
        bit calm;
        src_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0102};
        dst_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_AAAA};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store cases, extremes, duplicates, fill to full
        send(make_cmd(pbs_pkg::CMD_PURGE, '0, '0, '0, '0, 6'd32), 1'b1);
        send(make_cmd(pbs_pkg::CMD_TAKE, '0, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_QUERY, '0, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_INSERT, '1, '1, 16'hFFFF, 8'hFF, 6'h3F), 1'b1);
        send(make_cmd(pbs_pkg::CMD_INSERT, '1, '1, 16'hFFFF, 8'hFF, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_INSERT, '1, '1, 16'h0000, 8'h00, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_QUERY, '1, '1, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_QUERY, '1, 32'h1, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_TAKE, '1, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_PURGE, '0, '0, '0, '0, 6'd0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_INSERT, '1, '1, 16'hFFFF, 8'hFF, '0), 1'b1);
        for (int i = 0; i < 31; i++)
            send(make_cmd(pbs_pkg::CMD_INSERT, 32'(i), 32'h5555_AAAA, 16'(i), 8'h5A, '0),
                 1'b0);
        send(make_cmd(pbs_pkg::CMD_INSERT, 32'h7, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_TAKE, '1, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_TAKE, '1, '0, '0, '0, '0), 1'b1);
        send(make_cmd(pbs_pkg::CMD_PURGE, '0, '0, '0, '0, 6'd63), 1'b1);
        in_valid <= 1'b0;

        // hold off until every result is back
        drain();
        repeat (40) @(posedge clk);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 100 == 0)
                calm = $urandom_range(0, 2) == 0;
            send(random_cmd($urandom_range(0, 9) == 0), !calm);
        end
        in_valid <= 1'b0;

        drain();
        repeat (50) @(posedge clk);
        $display("run covered %0d results over directed and random command mixes",
                 result_count);
        $display("store filled, drained, duplicates, takes and partial purges exercised");
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
